// File: rtl/vns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vns_pkg;
    localparam int MAX_SEEDS  = 64;
    localparam int IDX_W      = $clog2(MAX_SEEDS);
    localparam int COORD_BITS = 12;
    localparam int KEY_W      = 2 * COORD_BITS + 1;
    localparam int FRAC_BITS  = 8;
    localparam int ROOT_W     = (KEY_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CNT_W      = 7;
    localparam int STEP_W     = $clog2(ROOT_W + 1);

    localparam logic       CMD_LOAD    = 1'b0;
    localparam logic       CMD_SHADE   = 1'b1;
    localparam logic       MET_EUCLID  = 1'b0;
    localparam logic       MET_MANH    = 1'b1;
    localparam logic [1:0] CM_GRAY     = 2'd0;
    localparam logic [1:0] CM_CYAN     = 2'd1;
    localparam logic [1:0] CM_EDGE     = 2'd2;
    localparam logic [1:0] CM_PALETTE  = 2'd3;
    localparam logic [1:0] REG_COUNT   = 2'd0;
    localparam logic [1:0] REG_METRIC  = 2'd1;
    localparam logic [1:0] REG_MODE    = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key1;
        logic [KEY_W-1:0] key2;
        logic             have2;
        logic [23:0]      col;
    } t_link;

    typedef struct packed {
        logic                  load;
        logic [IDX_W-1:0]      index;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [23:0]           col;
    } t_load;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQ1,
        ST_SQ2,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// File: rtl/vns_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module vns_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [vns_pkg::IDX_W-1:0]         i_index,
    input  wire logic [vns_pkg::CNT_W-1:0]         i_count,
    input  wire logic                              i_metric,
    input  wire logic [vns_pkg::COORD_BITS-1:0]    i_px,
    input  wire logic [vns_pkg::COORD_BITS-1:0]    i_py,
    input  wire vns_pkg::t_load                    i_load,
    input  wire vns_pkg::t_link                    i_link,
    output vns_pkg::t_link                         o_link
);
    logic [vns_pkg::COORD_BITS-1:0] r_x, r_y, dx, dy;
    logic [23:0]                    r_col;
    logic [vns_pkg::KEY_W-1:0]      key;
    logic                           active;
    vns_pkg::t_link                 r_link, n_link;

    always_ff @(posedge i_clk) begin
        if (i_load.load && i_load.index == i_index) begin
            r_x   <= i_load.x;
            r_y   <= i_load.y;
            r_col <= i_load.col;
        end
    end

    always_comb begin
        dx = (i_px >= r_x) ? i_px - r_x : r_x - i_px;
        dy = (i_py >= r_y) ? i_py - r_y : r_y - i_py;
        if (i_metric == vns_pkg::MET_MANH) begin
            key = vns_pkg::KEY_W'(dx) + vns_pkg::KEY_W'(dy);
        end else begin
            key = vns_pkg::KEY_W'(dx * dx) + vns_pkg::KEY_W'(dy * dy);
        end
        active = vns_pkg::CNT_W'(i_index) < i_count;
        n_link = i_link;
        if (i_link.valid && active) begin
            if (i_index == '0) begin
                n_link.key1  = key;
                n_link.col   = r_col;
                n_link.have2 = 1'b0;
            end else if (key < i_link.key1) begin
                n_link.key2  = i_link.key1;
                n_link.have2 = 1'b1;
                n_link.key1  = key;
                n_link.col   = r_col;
            end else if (!i_link.have2 || key < i_link.key2) begin
                n_link.key2  = key;
                n_link.have2 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;
endmodule
`default_nettype wire

// File: rtl/vns_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module vns_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [vns_pkg::RAD_W-1:0]     i_radicand,
    output logic                               o_done,
    output logic [vns_pkg::ROOT_W-1:0]         o_root,
    output logic                               o_rem_nz
);
    logic                            r_busy, r_done;
    logic [vns_pkg::STEP_W-1:0]      r_cnt;
    logic [vns_pkg::RAD_W-1:0]       r_rad;
    logic [vns_pkg::ROOT_W-1:0]      r_root;
    logic [vns_pkg::REM_W-1:0]       r_rem, shifted, trial;

    always_comb begin
        shifted = {r_rem[vns_pkg::REM_W-3:0], r_rad[vns_pkg::RAD_W-1 -: 2]};
        trial   = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= vns_pkg::STEP_W'(vns_pkg::ROOT_W);
                r_rad  <= i_radicand;
                r_root <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (shifted >= trial) begin
                    r_rem  <= shifted - trial;
                    r_root <= {r_root[vns_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted;
                    r_root <= {r_root[vns_pkg::ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - vns_pkg::STEP_W'(1);
                if (r_cnt == vns_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_root   = r_root;
    assign o_rem_nz = |r_rem;
endmodule
`default_nettype wire

// File: rtl/voronoi_nearest_seed_shader.sv
// Channel    Direction  Handshake                    Payload
// command    in         i_start high, o_busy low     i_command .. i_seed_blue
// result     out        o_valid strobe, one cycle    o_out_red, o_out_green, o_out_blue
// config     in         i_cfg_valid and o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load takes effect at its transfer and leaves the block free in the next cycle.
// A shade runs through the 64-cell seed chain, then, for Euclidean distance, through a
// bit-serial square root (one root for gray and cyan, two for edge, none for palette or
// for edge with a single seed); the result strobe is registered from state ST_OUT.
// Reset is synchronous and active low; the seed table is not cleared.
// The receiver cannot stall; o_busy stays high until the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module voronoi_nearest_seed_shader (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_command,
    input  wire logic [5:0]  i_seed_index,
    input  wire logic [11:0] i_pos_x,
    input  wire logic [11:0] i_pos_y,
    input  wire logic [7:0]  i_seed_red,
    input  wire logic [7:0]  i_seed_green,
    input  wire logic [7:0]  i_seed_blue,
    output logic             o_valid,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);
    localparam int N = vns_pkg::MAX_SEEDS;
    localparam int KW = vns_pkg::KEY_W;
    localparam int RW = vns_pkg::ROOT_W;

    logic [vns_pkg::CNT_W-1:0]      r_count, eff_count;
    logic                           r_metric;
    logic [1:0]                     r_mode;
    logic                           r_busy, r_go, accept;
    logic [vns_pkg::COORD_BITS-1:0] r_px, r_py;
    vns_pkg::t_load                 load;
    vns_pkg::t_link                 link_head;
    vns_pkg::t_link                 links [N+1];
    vns_pkg::t_state                r_state, n_state;
    logic [KW-1:0]                  r_key1, r_key2;
    logic                           r_have2;
    logic [23:0]                    r_col;
    logic [RW-1:0]                  r_s1, r_s2, sq_root, diff;
    logic                           r_nz1, sq_done, sq_nz, sq_start;
    logic [vns_pkg::RAD_W-1:0]      sq_rad;
    logic [KW-1:0]                  d1;
    logic [7:0]                     v, red, green, blue;
    logic                           r_valid;
    logic [7:0]                     r_red, r_green, r_blue;

    assign o_cfg_ready = 1'b1;
    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= vns_pkg::CNT_W'(1);
            r_metric <= vns_pkg::MET_EUCLID;
            r_mode   <= vns_pkg::CM_GRAY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vns_pkg::REG_COUNT:  r_count  <= i_cfg_data;
                vns_pkg::REG_METRIC: r_metric <= i_cfg_data[0];
                vns_pkg::REG_MODE:   r_mode   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_count == '0) begin
            eff_count = vns_pkg::CNT_W'(1);
        end else if (r_count > vns_pkg::CNT_W'(N)) begin
            eff_count = vns_pkg::CNT_W'(N);
        end else begin
            eff_count = r_count;
        end
        load.load  = accept && i_command == vns_pkg::CMD_LOAD;
        load.index = i_seed_index;
        load.x     = i_pos_x[vns_pkg::COORD_BITS-1:0];
        load.y     = i_pos_y[vns_pkg::COORD_BITS-1:0];
        load.col   = {i_seed_red, i_seed_green, i_seed_blue};
        link_head       = '0;
        link_head.valid = r_go;
    end

    assign links[0] = link_head;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= i_pos_x[vns_pkg::COORD_BITS-1:0];
            r_py <= i_pos_y[vns_pkg::COORD_BITS-1:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            vns_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_index  (vns_pkg::IDX_W'(g)),
                .i_count  (eff_count),
                .i_metric (r_metric),
                .i_px     (r_px),
                .i_py     (r_py),
                .i_load   (load),
                .i_link   (links[g]),
                .o_link   (links[g+1])
            );
        end
    endgenerate

    vns_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root),
        .o_rem_nz   (sq_nz)
    );

    always_comb begin
        n_state  = r_state;
        sq_start = 1'b0;
        sq_rad   = vns_pkg::RAD_W'({links[N].key1, {(2*vns_pkg::FRAC_BITS){1'b0}}});
        unique case (r_state)
            vns_pkg::ST_IDLE: begin
                if (links[N].valid) begin
                    if (r_metric == vns_pkg::MET_EUCLID && r_mode != vns_pkg::CM_PALETTE
                        && !(r_mode == vns_pkg::CM_EDGE && !links[N].have2)) begin
                        sq_start = 1'b1;
                        n_state  = vns_pkg::ST_SQ1;
                    end else begin
                        n_state = vns_pkg::ST_OUT;
                    end
                end
            end
            vns_pkg::ST_SQ1: begin
                if (sq_done) begin
                    if (r_mode == vns_pkg::CM_EDGE) begin
                        sq_start = 1'b1;
                        sq_rad   = vns_pkg::RAD_W'({r_key2, {(2*vns_pkg::FRAC_BITS){1'b0}}});
                        n_state  = vns_pkg::ST_SQ2;
                    end else begin
                        n_state = vns_pkg::ST_OUT;
                    end
                end
            end
            vns_pkg::ST_SQ2: begin
                if (sq_done) begin
                    n_state = vns_pkg::ST_OUT;
                end
            end
            vns_pkg::ST_OUT: n_state = vns_pkg::ST_IDLE;
            default:         n_state = vns_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == vns_pkg::ST_IDLE && links[N].valid) begin
            r_key1  <= links[N].key1;
            r_key2  <= links[N].key2;
            r_have2 <= links[N].have2;
            r_col   <= links[N].col;
        end
        if (r_state == vns_pkg::ST_SQ1 && sq_done) begin
            r_s1  <= sq_root;
            r_nz1 <= sq_nz;
        end
        if (r_state == vns_pkg::ST_SQ2 && sq_done) begin
            r_s2 <= sq_root;
        end
    end

    always_comb begin
        if (r_metric == vns_pkg::MET_MANH) begin
            d1   = r_key1;
            diff = RW'(r_key2 - r_key1);
        end else begin
            d1   = KW'(r_s1 >> vns_pkg::FRAC_BITS) + KW'(r_nz1);
            diff = (r_s2 - r_s1) >> vns_pkg::FRAC_BITS;
        end
        v = (d1 >= KW'(255)) ? 8'd0 : 8'(KW'(255) - d1);
        red   = v;
        green = v;
        blue  = v;
        case (r_mode)
            vns_pkg::CM_CYAN: begin
                green = 8'd0;
                blue  = (8'd255 - v) >> 1;
            end
            vns_pkg::CM_EDGE: begin
                if (!r_have2) begin
                    red = 8'd0;
                end else if (diff > RW'(255)) begin
                    red = 8'd255;
                end else begin
                    red = diff[7:0];
                end
                green = red;
                blue  = 8'd0;
            end
            vns_pkg::CM_PALETTE: begin
                red   = r_col[23:16];
                green = r_col[15:8];
                blue  = r_col[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == vns_pkg::ST_OUT) begin
            r_red   <= red;
            r_green <= green;
            r_blue  <= blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vns_pkg::ST_IDLE;
            r_busy  <= 1'b0;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= accept && i_command == vns_pkg::CMD_SHADE;
            r_valid <= r_state == vns_pkg::ST_OUT;
            if (accept && i_command == vns_pkg::CMD_SHADE) begin
                r_busy <= 1'b1;
            end else if (r_state == vns_pkg::ST_OUT) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;
endmodule
`default_nettype wire
